// File: src/keyframe_vector_interpolator_core_defines.svh
// Assertion helpers shared by the keyframe interpolator RTL.
// Each macro expands to one labelled concurrent assertion on the rising edge of aclk.
// Checking is suspended while aresetn is low.
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_CORE_DEFINES_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KVI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KVI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/kvi_pkg.sv
`timescale 1ns / 1ps

package kvi_pkg;

    // Field widths of the stream items.
    localparam int KIND_W   = 2;
    localparam int TIME_W   = 24;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    // Interpolation fraction: Q0.16 with one extra bit so that 1.0 is exact.
    localparam int FRAC_W   = 17;
    localparam int DIV_CNT_W = $clog2(FRAC_W + 1);

    localparam int DEFAULT_MAX_KEYS = 64;

    // Command kinds carried in tuser.
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ORDER = 2'd3;

    // Vector component selection inside the interpolation unit.
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] z;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] x;
    } vec_t;

    typedef struct packed {
        logic [TIME_W-1:0] ktime;
        vec_t              kvec;
    } key_t;

    localparam int KEY_W = $bits(key_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SCAN,
        ST_DIV,
        ST_LERP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        LP_IDLE,
        LP_SUB,
        LP_MUL,
        LP_ADD
    } lerp_phase_t;

endpackage

// File: src/kvi_ram.sv
`timescale 1ns / 1ps

module kvi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/kvi_div.sv
`timescale 1ns / 1ps

module kvi_div
    import kvi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TIME_W-1:0] offset,
    input  logic [TIME_W-1:0] span,
    output logic              done,
    output logic [FRAC_W-1:0] frac
);

    logic [TIME_W-1:0]    rem_reg;
    logic [TIME_W-1:0]    span_reg;
    logic [FRAC_W-1:0]    q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 first_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [TIME_W:0]      shifted;
    logic [TIME_W:0]      trial;
    logic                 fits;
    logic [TIME_W-1:0]    rem_next;

    // Restoring step. The offset never exceeds the span, so the first step
    // compares the offset itself and yields the integer bit of the fraction.
    always_comb begin
        shifted  = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        trial    = shifted - {1'b0, span_reg};
        fits     = shifted >= {1'b0, span_reg};
        rem_next = fits ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
    end

    // Sequencing: one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(FRAC_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= offset;
            span_reg  <= span;
            q_reg     <= '0;
            first_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            q_reg     <= {q_reg[FRAC_W-2:0], fits};
            first_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign frac = q_reg;

endmodule

// File: src/kvi_lerp.sv
`timescale 1ns / 1ps

module kvi_lerp
    import kvi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  vec_t              vec_a,
    input  vec_t              vec_b,
    input  logic [FRAC_W-1:0] frac,
    output logic              done,
    output vec_t              result
);

    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;

    lerp_phase_t phase_reg;
    lerp_phase_t phase_next;

    logic [1:0]               comp_reg;
    logic [FRAC_W-1:0]        frac_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    vec_t                     res_reg;
    logic                     done_reg;

    logic signed [VAL_W-1:0]  a_c;
    logic signed [VAL_W-1:0]  b_c;
    logic signed [FRAC_W:0]   frac_s;
    logic signed [PROD_W-1:0] sum;
    logic                     last_comp;

    // Phase sequence: subtract, multiply, add, once per component.
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            LP_IDLE: if (start) phase_next = LP_SUB;
            LP_SUB:  phase_next = LP_MUL;
            LP_MUL:  phase_next = LP_ADD;
            LP_ADD:  phase_next = last_comp ? LP_IDLE : LP_SUB;
        endcase
    end

    // Operand selection for the component under work.
    always_comb begin
        unique case (comp_reg)
            COMP_X: begin
                a_c = vec_a.x;
                b_c = vec_b.x;
            end
            COMP_Y: begin
                a_c = vec_a.y;
                b_c = vec_b.y;
            end
            default: begin
                a_c = vec_a.z;
                b_c = vec_b.z;
            end
        endcase
        last_comp = comp_reg == COMP_Z;
        frac_s    = $signed({1'b0, frac_reg});
        // The arithmetic shift rounds the scaled step towards minus infinity.
        sum       = PROD_W'(a_c) + (prod_reg >>> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= LP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == LP_ADD) && last_comp;
        end
    end

    // Shared datapath: one subtractor, one multiplier and one adder.
    always_ff @(posedge aclk) begin
        unique case (phase_reg)
            LP_IDLE: begin
                if (start) begin
                    frac_reg <= frac;
                    comp_reg <= COMP_X;
                end
            end
            LP_SUB: diff_reg <= DIFF_W'(b_c) - DIFF_W'(a_c);
            LP_MUL: prod_reg <= diff_reg * frac_s;
            LP_ADD: begin
                unique case (comp_reg)
                    COMP_X:  res_reg.x <= sum[VAL_W-1:0];
                    COMP_Y:  res_reg.y <= sum[VAL_W-1:0];
                    default: res_reg.z <= sum[VAL_W-1:0];
                endcase
                comp_reg <= comp_reg + 1'b1;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: src/keyframe_vector_interpolator_core.sv
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                              tuser
// s_        in   sample_time[23:0] value_x value_y value_z, 120  kind[1:0]
// m_        out  out_x out_y out_z, 96 bits                      status[1:0]
//
// Clear and append skip the key search. A query reads one key per cycle through
// the single read port of the key memory while the segment is searched, then runs
// the bit-serial divider and the shared subtract-multiply-add unit for the three
// components. s_tready is high only between items; a finished result sits in the
// output register, and the next item is accepted while it waits to be taken.
// aresetn is synchronous and empties the table; key memory contents are not cleared.

`include "keyframe_vector_interpolator_core_defines.svh"

module keyframe_vector_interpolator_core
    import kvi_pkg::*;
#(
    parameter int MAX_KEYS = DEFAULT_MAX_KEYS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,  // sample_time, value_x, value_y, value_z
    input  logic [1:0]   s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // out_x, out_y, out_z
    output logic [1:0]   m_tuser   // status
);

    localparam int ADDR_W = $clog2(MAX_KEYS);
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]    count_reg;
    logic [TIME_W-1:0]   last_time_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   addr_next;
    key_t                prev_reg;
    vec_t                cur_reg;
    vec_t                res_vec_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                m_tvalid_reg;
    logic [95:0]         m_data_reg;
    logic [1:0]          m_user_reg;

    logic [TIME_W-1:0]   s_time;
    vec_t                s_vec;
    logic [KIND_W-1:0]   s_kind;
    logic                s_accept;
    logic                full;
    logic                order_err;
    logic                ram_we;
    key_t                ram_wdata;
    logic [KEY_W-1:0]    ram_rdata;
    key_t                rd_key;
    logic                before_key;
    logic [TIME_W-1:0]   span;
    logic [TIME_W-1:0]   offset;
    logic [CNT_W-1:0]    count_m1;
    logic                at_last;
    logic                single_key;
    logic                out_free;
    logic                div_start;
    logic                div_done;
    logic [FRAC_W-1:0]   div_frac;
    logic                lerp_start;
    logic                lerp_done;
    vec_t                lerp_res;

    // Unpack the input item.
    assign s_time   = s_tdata[TIME_W-1:0];
    assign s_vec.x  = s_tdata[TIME_W +: VAL_W];
    assign s_vec.y  = s_tdata[TIME_W + VAL_W +: VAL_W];
    assign s_vec.z  = s_tdata[TIME_W + 2*VAL_W +: VAL_W];
    assign s_kind   = s_tuser;
    assign s_tready = state_reg == ST_IDLE;
    assign s_accept = s_tvalid && s_tready;

    // Key table decisions and segment arithmetic.
    always_comb begin
        full       = count_reg >= CNT_W'(MAX_KEYS);
        order_err  = (count_reg != '0) && (s_time < last_time_reg);
        rd_key     = key_t'(ram_rdata);
        before_key = time_reg <= rd_key.ktime;
        span       = rd_key.ktime - prev_reg.ktime;
        offset     = time_reg - prev_reg.ktime;
        count_m1   = count_reg - CNT_W'(1);
        at_last    = addr_reg == count_m1[ADDR_W-1:0];
        single_key = count_reg == CNT_W'(1);
        out_free   = !m_tvalid_reg || m_tready;
        ram_wdata.ktime = s_time;
        ram_wdata.kvec  = s_vec;
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_kind == KIND_QUERY && count_reg != '0) begin
                        state_next = ST_FIRST;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FIRST: begin
                state_next = (single_key || before_key) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (before_key) begin
                    state_next = (span == '0) ? ST_DONE : ST_DIV;
                end else if (at_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:  if (div_done) state_next = ST_LERP;
            ST_LERP: if (lerp_done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory address, write strobe and unit starts.
    always_comb begin
        addr_next  = addr_reg;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        lerp_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                addr_next = '0;
                ram_we    = s_accept && (s_kind == KIND_APPEND) && !full && !order_err;
            end
            ST_FIRST: addr_next = ADDR_W'(1);
            ST_SCAN: begin
                if (before_key) begin
                    div_start = span != '0;
                end else if (!at_last) begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DIV:  lerp_start = div_done;
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            addr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            if (s_accept && s_kind == KIND_CLEAR) begin
                count_reg <= '0;
            end else if (ram_we) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: command, segment end points and the result.
    always_ff @(posedge aclk) begin
        if (ram_we) begin
            last_time_reg <= s_time;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    time_reg    <= s_time;
                    res_vec_reg <= '0;
                    priority if (s_kind == KIND_APPEND && full) begin
                        res_status_reg <= STAT_FULL;
                    end else if (s_kind == KIND_APPEND && order_err) begin
                        res_status_reg <= STAT_ORDER;
                    end else if (s_kind == KIND_QUERY && count_reg == '0) begin
                        res_status_reg <= STAT_EMPTY;
                    end else begin
                        res_status_reg <= STAT_OK;
                    end
                end
            end
            ST_FIRST: begin
                prev_reg    <= rd_key;
                res_vec_reg <= rd_key.kvec;
            end
            ST_SCAN: begin
                if (before_key) begin
                    // A zero-length segment answers with the earlier key.
                    cur_reg     <= rd_key.kvec;
                    res_vec_reg <= prev_reg.kvec;
                end else begin
                    // Past the last key the last key's value stands.
                    prev_reg    <= rd_key;
                    res_vec_reg <= rd_key.kvec;
                end
            end
            ST_LERP: if (lerp_done) res_vec_reg <= lerp_res;
            default: ;
        endcase
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= {res_vec_reg.z, res_vec_reg.y, res_vec_reg.x};
            m_user_reg <= res_status_reg;
        end
    end

    kvi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (addr_next),
        .rdata (ram_rdata)
    );

    kvi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .offset  (offset),
        .span    (span),
        .done    (div_done),
        .frac    (div_frac)
    );

    kvi_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lerp_start),
        .vec_a   (prev_reg.kvec),
        .vec_b   (cur_reg),
        .frac    (div_frac),
        .done    (lerp_done),
        .result  (lerp_res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `KVI_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_KEYS), "key count above table size")
    `KVI_ASSERT_SAME(a_scan_in_table, state_reg == ST_SCAN, CNT_W'(addr_reg) < count_reg, "scan address beyond stored keys")
    `KVI_ASSERT_SAME(a_div_done_state, div_done, state_reg == ST_DIV, "divider finished outside the divide state")
    `KVI_ASSERT_NEXT(a_write_grows, ram_we, count_reg == $past(count_reg) + 1'b1, "append did not grow the table")

endmodule

// File: test/keyframe_vector_interpolator_core_test.sv
`timescale 1ns / 1ps

module keyframe_vector_interpolator_core_test;
    import kvi_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_MAX_KEYS;
    localparam int unsigned TIME_MAX = (1 << TIME_W) - 1;
    localparam int ITEM_GOAL = 450;
    localparam int HOLD_AT = 40;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_CYCLES = 150;
    localparam int unsigned CYCLE_LIMIT = 600000;

    // The fourth command code is left unused by the block and must be answered harmlessly.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        vec_t                vec;
        logic [STATUS_W-1:0] status;
    } answer_t;

    // Mirror of the keyframe table that works out the answer to every accepted command.
    class keyframe_table_mirror;
        logic [TIME_W-1:0] key_time [TABLE_DEPTH];
        vec_t              key_vec [TABLE_DEPTH];
        int unsigned       key_total;
        answer_t           pending_answers[$];
        int unsigned       mismatches;
        int unsigned       interp_hits, edge_hits, empty_hits, full_refusals, order_refusals;
        int unsigned       peak_keys;

        function new();
            key_total = 0;
            mismatches = 0;
            interp_hits = 0;
            edge_hits = 0;
            empty_hits = 0;
            full_refusals = 0;
            order_refusals = 0;
            peak_keys = 0;
        endfunction

        // a + floor((b - a) * frac / 2^16), the arithmetic shift rounding towards minus infinity.
        function logic signed [VAL_W-1:0] blend(logic signed [VAL_W-1:0] a,
                                                logic signed [VAL_W-1:0] b,
                                                logic [FRAC_W-1:0] frac);
            longint delta;
            longint prod;
            delta = longint'(b) - longint'(a);
            prod = delta * longint'({1'b0, frac});
            return VAL_W'(longint'(a) + (prod >>> 16));
        endfunction

        // Linear blend across the segment that starts at key seg.
        function vec_t interpolate(int seg, logic [TIME_W-1:0] s);
            vec_t              lo_key, hi_key, mixed;
            longint            span;
            logic [FRAC_W-1:0] frac;
            lo_key = key_vec[seg];
            hi_key = key_vec[seg + 1];
            span = longint'(key_time[seg + 1]) - longint'(key_time[seg]);
            if (span == 0) return lo_key;
            frac = FRAC_W'(((longint'(s) - longint'(key_time[seg])) <<< 16) / span);
            mixed.x = blend(lo_key.x, hi_key.x, frac);
            mixed.y = blend(lo_key.y, hi_key.y, frac);
            mixed.z = blend(lo_key.z, hi_key.z, frac);
            return mixed;
        endfunction

        // Update the table for one accepted item and queue the answer it must produce.
        function void note_command(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] s, vec_t v);
            answer_t ans;
            bit      hit;
            ans = '0;
            hit = 1'b0;
            case (kind)
                KIND_CLEAR: begin
                    key_total = 0;
                end
                KIND_APPEND: begin
                    if (key_total >= TABLE_DEPTH) begin
                        ans.status = STAT_FULL;
                        full_refusals++;
                    end else if (key_total > 0 && s < key_time[key_total - 1]) begin
                        ans.status = STAT_ORDER;
                        order_refusals++;
                    end else begin
                        key_time[key_total] = s;
                        key_vec[key_total] = v;
                        key_total++;
                        if (key_total > peak_keys) peak_keys = key_total;
                    end
                end
                KIND_QUERY: begin
                    if (key_total == 0) begin
                        ans.status = STAT_EMPTY;
                        empty_hits++;
                    end else if (key_total == 1 || s <= key_time[0]) begin
                        ans.vec = key_vec[0];
                        edge_hits++;
                    end else begin
                        for (int seg = 0; seg + 1 < key_total; seg++) begin
                            if (!hit && s <= key_time[seg + 1]) begin
                                ans.vec = interpolate(seg, s);
                                hit = 1'b1;
                            end
                        end
                        if (hit) begin
                            interp_hits++;
                        end else begin
                            // Past the last key the last key's value holds.
                            ans.vec = key_vec[key_total - 1];
                            edge_hits++;
                        end
                    end
                end
                default: begin
                end
            endcase
            pending_answers = {pending_answers, ans};
        endfunction

        // Compare one accepted result against the oldest queued answer.
        function void check_answer(vec_t got, logic [STATUS_W-1:0] got_status);
            answer_t oldest;
            if (pending_answers.size() == 0) begin
                $display("%0t: result with nothing outstanding: vector %h status %0d",
                         $time, got, got_status);
                mismatches++;
                return;
            end
            oldest = pending_answers.pop_front();
            for (int k = 0; k < 3; k++) begin
                if (got[k*VAL_W +: VAL_W] !== oldest.vec[k*VAL_W +: VAL_W]) begin
                    $display("%0t: component %0d expected %h, got %h", $time, k,
                             oldest.vec[k*VAL_W +: VAL_W], got[k*VAL_W +: VAL_W]);
                    mismatches++;
                end
            end
            if (got_status !== oldest.status) begin
                $display("%0t: status expected %0d, got %0d", $time, oldest.status, got_status);
                mismatches++;
            end
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [119:0]  s_tdata = '0;  // sample_time, value_x, value_y, value_z
    logic [1:0]    s_tuser = '0;  // kind
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [95:0]   m_tdata;  // out_x, out_y, out_z
    logic [1:0]    m_tuser;  // status

    keyframe_table_mirror mirror = new();
    logic [TIME_W-1:0]    seq_times[$];
    bit                   burst_mode = 1'b0;
    int unsigned          items_sent = 0;

    keyframe_vector_interpolator_core #(
        .MAX_KEYS(TABLE_DEPTH)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #1 aclk = ~aclk;

    // Offer one item and return at the edge where it is taken; tvalid stays high afterwards.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] s,
                             input vec_t v);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {v, s};
        s_tuser <= kind;
        do @(posedge aclk); while (s_tready !== 1'b1);
        mirror.note_command(kind, s, v);
        items_sent++;
    endtask

    // Key vectors lean towards the extremes of the Q16.16 range and towards small values.
    function automatic vec_t random_vec();
        vec_t v;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
                0: v[k*VAL_W +: VAL_W] = 32'h7fffffff;
                1: v[k*VAL_W +: VAL_W] = 32'h80000000;
                2: v[k*VAL_W +: VAL_W] = VAL_W'($urandom_range(0, 2000)) - 32'd1000;
                default: v[k*VAL_W +: VAL_W] = $urandom;
            endcase
        end
        return v;
    endfunction

    // Query times mostly land inside the stored span, with some on keys and off either end.
    function automatic logic [TIME_W-1:0] pick_query_time();
        int unsigned lo, hi, t;
        if (seq_times.size() == 0) return TIME_W'($urandom);
        lo = seq_times[0];
        hi = seq_times[seq_times.size() - 1];
        case ($urandom_range(0, 6))
            0: t = $urandom & TIME_MAX;
            1: t = seq_times[$urandom_range(0, seq_times.size() - 1)];
            2: t = (hi + $urandom_range(1, 50) > TIME_MAX) ? TIME_MAX : hi + $urandom_range(1, 50);
            3: t = (lo < 50) ? 0 : lo - $urandom_range(0, 50);
            default: t = $urandom_range(lo, hi);
        endcase
        return TIME_W'(t);
    endfunction

    // Clear, build an ordered table with some refused keys mixed in, then query it.
    task automatic run_sequence(input int key_goal, input int query_goal);
        int unsigned cursor, step_cap;
        bit          wide;
        burst_mode = ($urandom_range(0, 3) == 0);
        seq_times.delete();
        send_item(KIND_CLEAR, TIME_W'($urandom), random_vec());
        wide = $urandom_range(0, 1);
        cursor = wide ? $urandom_range(0, 1 << 20) : ($urandom & TIME_MAX);
        step_cap = wide ? (TIME_MAX - cursor) / (key_goal + 1) : 16;
        for (int k = 0; k < key_goal; k++) begin
            cursor = cursor + $urandom_range(0, step_cap);
            if (cursor > TIME_MAX) cursor = TIME_MAX;
            seq_times = {seq_times, TIME_W'(cursor)};
            send_item(KIND_APPEND, TIME_W'(cursor), random_vec());
            if ($urandom_range(0, 9) == 0 && cursor > 0)
                send_item(KIND_APPEND, TIME_W'($urandom_range(0, cursor - 1)), random_vec());
            else if ($urandom_range(0, 19) == 0)
                send_item(KIND_SPARE, TIME_W'($urandom), random_vec());
        end
        for (int q = 0; q < query_goal; q++)
            send_item(KIND_QUERY, pick_query_time(), random_vec());
    endtask

    // Result side: random stalls, one long hold-off so the block backs up its input.
    initial begin : result_sink
        int pause;
        int taken;
        taken = 0;
        wait (aresetn === 1'b1);
        forever begin
            pause = burst_mode ? 0 : $urandom_range(0, 10);
            if (taken == HOLD_AT) pause = pause + HOLD_CYCLES;
            if (pause > 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            taken++;
            mirror.check_answer(vec_t'(m_tdata), m_tuser);
        end
    end

    // Run length guard.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("keyframe_vector_interpolator_core_test failed");
        $finish;
    end

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corner items; vectors are written {z, y, x}.
        send_item(KIND_QUERY, 24'd0, '0);
        send_item(KIND_APPEND, 24'd0, {32'd0, 32'h80000000, 32'h7fffffff});
        send_item(KIND_QUERY, 24'hffffff, '0);
        send_item(KIND_QUERY, 24'd0, '0);
        send_item(KIND_APPEND, 24'd1000, {32'hffffffff, 32'h7fffffff, 32'h80000000});
        send_item(KIND_QUERY, 24'd500, '0);
        send_item(KIND_QUERY, 24'd1, '0);
        send_item(KIND_QUERY, 24'd999, '0);
        send_item(KIND_QUERY, 24'd1000, '0);
        // A key sharing its time with the one before is accepted.
        send_item(KIND_APPEND, 24'd1000, {32'd12345, 32'hffffffff, 32'd1});
        send_item(KIND_APPEND, 24'd999, random_vec());
        send_item(KIND_QUERY, 24'd1000, '0);
        send_item(KIND_QUERY, 24'hffffff, '0);
        send_item(KIND_SPARE, 24'hffffff, {96{1'b1}});
        send_item(KIND_APPEND, 24'hffffff, {96{1'b1}});
        send_item(KIND_QUERY, 24'hfffffe, '0);
        send_item(KIND_CLEAR, 24'd0, '0);
        send_item(KIND_QUERY, 24'd123, '0);
        send_item(KIND_APPEND, 24'd5, random_vec());
        send_item(KIND_QUERY, 24'd0, '0);
        send_item(KIND_APPEND, 24'd9, random_vec());
        send_item(KIND_QUERY, 24'd0, '0);
        send_item(KIND_QUERY, 24'd7, '0);

        // One table filled past capacity, then mostly short tables.
        run_sequence(TABLE_DEPTH + 2, 8);
        while (items_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 9))
                0: run_sequence(0, $urandom_range(1, 3));
                1: run_sequence($urandom_range(9, 30), $urandom_range(4, 12));
                default: run_sequence($urandom_range(1, 8), $urandom_range(2, 10));
            endcase
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        while (mirror.pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d items: %0d interpolated queries, %0d end-of-table queries,",
                 items_sent, mirror.interp_hits, mirror.edge_hits);
        $display("%0d empty-table queries, %0d full and %0d out-of-order refusals, %0d keys at most.",
                 mirror.empty_hits, mirror.full_refusals, mirror.order_refusals, mirror.peak_keys);
        if (mirror.mismatches == 0 && mirror.pending_answers.size() == 0) begin
            $display("keyframe_vector_interpolator_core_test passed");
        end else begin
            $display("keyframe_vector_interpolator_core_test failed");
        end
        $finish;
    end

endmodule

// File: keyframe_vector_interpolator_core.f
+incdir+src
src/kvi_pkg.sv
src/kvi_ram.sv
src/kvi_div.sv
src/kvi_lerp.sv
src/keyframe_vector_interpolator_core.sv
test/keyframe_vector_interpolator_core_test.sv
